/* rtl/core/lrs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, word types and codes of the linear resampler.
package lrs_pkg;

    localparam int unsigned OUTPUT_RATE = 44100;
    localparam int unsigned RATE_MIN    = 8000;
    localparam int unsigned RATE_MAX    = 192000;
    localparam int unsigned RATE_RESET  = 44100;

    localparam int SAMPLE_W     = 16;
    localparam int RATE_W       = 18;
    localparam int PHASE_W      = 18;
    localparam int PHASE_SUM_W  = PHASE_W + 1;
    localparam int FRAC_W       = 16;
    localparam int POS_W        = 19;
    localparam int POS_SUM_W    = POS_W + 1;
    localparam int LANE_LATENCY = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 18;

    // Reciprocal of the output rate, exact for numerators below 2**31.
    localparam int RECIP_SHIFT = 47;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE));

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_RATE   = 1'b0,
        REG_STEREO_INPUT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        TK_SAMPLE = 1'b0,
        TK_TERM   = 1'b1
    } token_kind_t;

    typedef struct packed {
        sample_t left_in;
        sample_t right_in;
        logic    end_of_track;
    } frame_word_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    sample_valid;
        logic    last;
    } result_word_t;

    typedef struct packed {
        cfg_reg_t                index;
        logic [CFG_DATA_W-1:0]   data;
    } cfg_word_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic        end_item;
    } tag_t;

    typedef struct packed {
        sample_t           a;
        sample_t           b;
        logic [FRAC_W-1:0] frac;
    } lane_op_t;

endpackage

/* rtl/core/lrs_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel that carries one word of a given payload type.
interface lrs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/linear_resampler_to_44k1_stereo_unit.sv */
`timescale 1ns / 1ps
// Top level of the linear-interpolation resampler to 44100 Hz stereo.
// Input frames are taken one at a time. The first frame of a track is only stored as the
// previous frame, unless it also ends the track. Any later frame is accepted, then settles
// an output held back from an earlier frame if one is waiting, steps every output position
// that falls between it and the previous frame, and is closed. The end-of-track frame
// then steps each trailing position, closes the tail and issues the closing word. The pace
// inside a track is set by the phase stepper, which visits one output position per cycle
// while the output is not stalled. Each channel runs through its own four-stage
// interpolation lane, whose result is then registered in the output register or, for the
// end frame, held back until it is known to be final. A stalled output stalls the lanes and
// the stepper together. Configuration writes are accepted in every cycle.
module linear_resampler_to_44k1_stereo_unit import lrs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    lrs_stream_if.sink    frames,
    lrs_stream_if.source  results,
    lrs_stream_if.sink    cfg
);
    logic [RATE_W-1:0] input_rate_reg, input_rate_next;
    logic              stereo_input_reg, stereo_input_next;
    logic              adv;
    tag_t              issue_tag;
    lane_op_t          op_left;
    lane_op_t          op_right;
    sample_t           left_res;
    sample_t           right_res;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        input_rate_next   = input_rate_reg;
        stereo_input_next = stereo_input_reg;
        if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_INPUT_RATE:   input_rate_next   = cfg.payload.data[RATE_W-1:0];
                REG_STEREO_INPUT: stereo_input_next = cfg.payload.data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_rate_reg   <= RATE_W'(RATE_RESET);
            stereo_input_reg <= 1'b1;
        end
        else
        begin
            input_rate_reg   <= input_rate_next;
            stereo_input_reg <= stereo_input_next;
        end
    end

    lrs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .frames       (frames),
        .input_rate   (input_rate_reg),
        .stereo_input (stereo_input_reg),
        .adv          (adv),
        .issue_tag    (issue_tag),
        .op_left      (op_left),
        .op_right     (op_right)
    );

    lrs_lane u_lane_left (
        .clk    (clk),
        .adv    (adv),
        .op     (op_left),
        .result (left_res)
    );

    lrs_lane u_lane_right (
        .clk    (clk),
        .adv    (adv),
        .op     (op_right),
        .result (right_res)
    );

    lrs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (issue_tag),
        .left_res  (left_res),
        .right_res (right_res),
        .adv       (adv),
        .results   (results)
    );

`ifndef SYNTH
    a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        frames.ready |-> !issue_tag.valid)
        else $error("Operation issued while the sequencer is waiting for a frame.");

    a_term_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        issue_tag.valid && issue_tag.kind == TK_TERM && adv |=> frames.ready)
        else $error("Sequencer did not return to idle after closing a track.");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.payload.sample_valid |->
            results.payload.last && results.payload.left_out == '0 &&
            results.payload.right_out == '0)
        else $error("End marker word is not a cleared final word.");
`endif
endmodule

/* rtl/core/lrs_lane.sv */
`timescale 1ns / 1ps
// One channel of the interpolator: four-stage blend of two samples by a phase.
module lrs_lane import lrs_pkg::*; (
    input  logic     clk,
    input  logic     adv,
    input  lane_op_t op,
    output sample_t  result
);
    localparam int PROD_W = SAMPLE_W + FRAC_W + 2;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = 31;
    localparam int QUOT_W = MAG_W + RECIP_W;
    localparam logic signed [SUM_W-1:0] RATE_S = SUM_W'(OUTPUT_RATE);

    logic signed [SAMPLE_W:0]   diff;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    sample_t                    base_reg;
    logic signed [SUM_W-1:0]    base_ext;
    logic signed [SUM_W-1:0]    prod_ext;
    logic signed [SUM_W-1:0]    total;
    logic signed [SUM_W-1:0]    total_abs;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg2_reg;
    logic [QUOT_W-1:0]          quot_reg;
    logic                       neg3_reg;
    logic [SAMPLE_W-1:0]        quot_int;
    sample_t                    result_reg;

    assign diff      = {op.b[SAMPLE_W-1], op.b} - {op.a[SAMPLE_W-1], op.a};
    assign frac_s    = {1'b0, op.frac};
    assign prod_next = diff * frac_s;

    assign base_ext  = {{(SUM_W-SAMPLE_W){base_reg[SAMPLE_W-1]}}, base_reg};
    assign prod_ext  = {prod_reg[PROD_W-1], prod_reg};
    assign total     = base_ext * RATE_S + prod_ext;
    assign total_abs = total[SUM_W-1] ? -total : total;

    assign quot_int  = quot_reg[RECIP_SHIFT +: SAMPLE_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= prod_next;
            base_reg   <= op.a;
            mag_reg    <= total_abs[MAG_W-1:0];
            neg2_reg   <= total[SUM_W-1];
            quot_reg   <= mag_reg * RECIP;
            neg3_reg   <= neg2_reg;
            result_reg <= neg3_reg ? (~quot_int + 1'b1) : quot_int;
        end
    end

    assign result = result_reg;
endmodule

/* rtl/core/lrs_seq.sv */
`timescale 1ns / 1ps
// Frame sequencer: steps the output phase and issues blend operations to the lanes.
module lrs_seq import lrs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    lrs_stream_if.sink         frames,
    input  logic [RATE_W-1:0]  input_rate,
    input  logic               stereo_input,
    input  logic               adv,
    output tag_t               issue_tag,
    output lane_op_t           op_left,
    output lane_op_t           op_right
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_RUN,
        S_TAIL,
        S_TERM
    } state_t;

    localparam logic [PHASE_W-1:0]         PHASE_OR     = PHASE_W'(OUTPUT_RATE);
    localparam logic [PHASE_SUM_W-1:0]     SPAN_ONE     = PHASE_SUM_W'(OUTPUT_RATE);
    localparam logic [PHASE_SUM_W-1:0]     SPAN_TWO     = PHASE_SUM_W'(2 * OUTPUT_RATE);
    localparam logic signed [POS_SUM_W-1:0] POS_SPAN_TWO = POS_SUM_W'(2 * OUTPUT_RATE);
    localparam logic signed [POS_W-1:0]    POS_OR       = POS_W'(OUTPUT_RATE);
    localparam logic [RATE_W-1:0]          RATE_LO      = RATE_W'(RATE_MIN);
    localparam logic [RATE_W-1:0]          RATE_HI      = RATE_W'(RATE_MAX);

    state_t                      state_reg, state_next;
    sample_t                     cur_l_reg, cur_l_next;
    sample_t                     cur_r_reg, cur_r_next;
    logic                        end_reg, end_next;
    logic [RATE_W-1:0]           rate_reg, rate_next;
    sample_t                     prev_l_reg, prev_l_next;
    sample_t                     prev_r_reg, prev_r_next;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic                        have_prev_reg, have_prev_next;
    logic                        pend_valid_reg, pend_valid_next;
    sample_t                     pend_al_reg, pend_al_next;
    sample_t                     pend_ar_reg, pend_ar_next;
    sample_t                     pend_bl_reg, pend_bl_next;
    sample_t                     pend_br_reg, pend_br_next;
    logic [FRAC_W-1:0]           pend_frac_reg, pend_frac_next;
    logic signed [POS_W-1:0]     pend_pos_reg, pend_pos_next;

    logic [RATE_W-1:0]           rate_clamped;
    sample_t                     frame_l;
    sample_t                     frame_r;
    logic [PHASE_SUM_W-1:0]      phase_sum;
    logic                        in_frame;
    logic signed [POS_SUM_W-1:0] settle_sum;

    always_comb
    begin
        if (input_rate < RATE_LO)
            rate_clamped = RATE_LO;
        else if (input_rate > RATE_HI)
            rate_clamped = RATE_HI;
        else
            rate_clamped = input_rate;
    end

    assign frame_l    = frames.payload.left_in;
    assign frame_r    = stereo_input ? frames.payload.right_in : frames.payload.left_in;
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, rate_reg};
    assign in_frame   = phase_reg < PHASE_OR;
    assign settle_sum = {pend_pos_reg[POS_W-1], pend_pos_reg} + {2'b00, rate_reg};

    always_comb
    begin
        state_next      = state_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        end_next        = end_reg;
        rate_next       = rate_reg;
        prev_l_next     = prev_l_reg;
        prev_r_next     = prev_r_reg;
        phase_next      = phase_reg;
        have_prev_next  = have_prev_reg;
        pend_valid_next = pend_valid_reg;
        pend_al_next    = pend_al_reg;
        pend_ar_next    = pend_ar_reg;
        pend_bl_next    = pend_bl_reg;
        pend_br_next    = pend_br_reg;
        pend_frac_next  = pend_frac_reg;
        pend_pos_next   = pend_pos_reg;
        issue_tag       = '0;
        op_left         = '0;
        op_right        = '0;
        frames.ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                frames.ready = 1'b1;
                if (frames.valid)
                begin
                    cur_l_next = frame_l;
                    cur_r_next = frame_r;
                    end_next   = frames.payload.end_of_track;
                    rate_next  = rate_clamped;
                    if (have_prev_reg)
                    begin
                        state_next = pend_valid_reg ? S_SETTLE : S_RUN;
                    end
                    else
                    begin
                        prev_l_next    = frame_l;
                        prev_r_next    = frame_r;
                        have_prev_next = 1'b1;
                        state_next     = frames.payload.end_of_track ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_SETTLE:
            begin
                if (adv)
                begin
                    if (settle_sum <= POS_SPAN_TWO)
                    begin
                        issue_tag       = '{valid: 1'b1, kind: TK_SAMPLE, end_item: end_reg};
                        op_left         = '{a: pend_al_reg, b: pend_bl_reg, frac: pend_frac_reg};
                        op_right        = '{a: pend_ar_reg, b: pend_br_reg, frac: pend_frac_reg};
                        pend_valid_next = 1'b0;
                    end
                    else if (end_reg)
                    begin
                        pend_valid_next = 1'b0;
                    end
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (adv)
                begin
                    if (in_frame)
                    begin
                        if (phase_sum <= SPAN_TWO)
                        begin
                            issue_tag = '{valid: 1'b1, kind: TK_SAMPLE, end_item: end_reg};
                            op_left   = '{a: prev_l_reg, b: cur_l_reg,
                                          frac: phase_reg[FRAC_W-1:0]};
                            op_right  = '{a: prev_r_reg, b: cur_r_reg,
                                          frac: phase_reg[FRAC_W-1:0]};
                        end
                        else if (!end_reg && !pend_valid_reg)
                        begin
                            pend_valid_next = 1'b1;
                            pend_al_next    = prev_l_reg;
                            pend_ar_next    = prev_r_reg;
                            pend_bl_next    = cur_l_reg;
                            pend_br_next    = cur_r_reg;
                            pend_frac_next  = phase_reg[FRAC_W-1:0];
                            pend_pos_next   = {1'b0, phase_reg};
                        end
                        phase_next = phase_sum[PHASE_W-1:0];
                    end
                    else
                    begin
                        phase_next = phase_reg - PHASE_OR;
                        if (pend_valid_reg)
                            pend_pos_next = pend_pos_reg - POS_OR;
                        prev_l_next = cur_l_reg;
                        prev_r_next = cur_r_reg;
                        state_next  = end_reg ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (adv)
                begin
                    if (in_frame)
                    begin
                        if (phase_sum <= SPAN_ONE)
                        begin
                            issue_tag = '{valid: 1'b1, kind: TK_SAMPLE, end_item: 1'b1};
                            op_left   = '{a: cur_l_reg, b: cur_l_reg,
                                          frac: phase_reg[FRAC_W-1:0]};
                            op_right  = '{a: cur_r_reg, b: cur_r_reg,
                                          frac: phase_reg[FRAC_W-1:0]};
                        end
                        phase_next = phase_sum[PHASE_W-1:0];
                    end
                    else
                    begin
                        state_next = S_TERM;
                    end
                end
            end
            S_TERM:
            begin
                if (adv)
                begin
                    issue_tag       = '{valid: 1'b1, kind: TK_TERM, end_item: 1'b1};
                    phase_next      = '0;
                    have_prev_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    prev_l_next     = '0;
                    prev_r_next     = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_l_reg      <= '0;
            cur_r_reg      <= '0;
            end_reg        <= 1'b0;
            rate_reg       <= RATE_W'(RATE_RESET);
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            phase_reg      <= '0;
            have_prev_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_al_reg    <= '0;
            pend_ar_reg    <= '0;
            pend_bl_reg    <= '0;
            pend_br_reg    <= '0;
            pend_frac_reg  <= '0;
            pend_pos_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_l_reg      <= cur_l_next;
            cur_r_reg      <= cur_r_next;
            end_reg        <= end_next;
            rate_reg       <= rate_next;
            prev_l_reg     <= prev_l_next;
            prev_r_reg     <= prev_r_next;
            phase_reg      <= phase_next;
            have_prev_reg  <= have_prev_next;
            pend_valid_reg <= pend_valid_next;
            pend_al_reg    <= pend_al_next;
            pend_ar_reg    <= pend_ar_next;
            pend_bl_reg    <= pend_bl_next;
            pend_br_reg    <= pend_br_next;
            pend_frac_reg  <= pend_frac_next;
            pend_pos_reg   <= pend_pos_next;
        end
    end
endmodule

/* rtl/core/lrs_merge.sv */
`timescale 1ns / 1ps
// Merging stage: joins the lane results into stereo words and marks the end of a track.
module lrs_merge import lrs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  tag_t          tag_in,
    input  sample_t       left_res,
    input  sample_t       right_res,
    output logic          adv,
    lrs_stream_if.source  results
);
    tag_t          tag_pipe_reg [LANE_LATENCY];
    tag_t          tag_head;
    logic          out_valid_reg, out_valid_next;
    result_word_t  out_word_reg, out_word_next;
    logic          hold_valid_reg, hold_valid_next;
    sample_t       hold_l_reg, hold_l_next;
    sample_t       hold_r_reg, hold_r_next;
    logic          push;
    result_word_t  push_word;

    assign adv      = !out_valid_reg || results.ready;
    assign tag_head = tag_pipe_reg[LANE_LATENCY-1];

    always_comb
    begin
        push            = 1'b0;
        push_word       = '0;
        hold_valid_next = hold_valid_reg;
        hold_l_next     = hold_l_reg;
        hold_r_next     = hold_r_reg;
        if (adv && tag_head.valid)
        begin
            unique case (tag_head.kind)
                TK_SAMPLE:
                begin
                    if (!tag_head.end_item)
                    begin
                        push      = 1'b1;
                        push_word = '{left_out: left_res, right_out: right_res,
                                      sample_valid: 1'b1, last: 1'b0};
                    end
                    else
                    begin
                        // The end frame keeps its newest word back until it is known to be final.
                        if (hold_valid_reg)
                        begin
                            push      = 1'b1;
                            push_word = '{left_out: hold_l_reg, right_out: hold_r_reg,
                                          sample_valid: 1'b1, last: 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_l_next     = left_res;
                        hold_r_next     = right_res;
                    end
                end
                TK_TERM:
                begin
                    push = 1'b1;
                    if (hold_valid_reg)
                        push_word = '{left_out: hold_l_reg, right_out: hold_r_reg,
                                      sample_valid: 1'b1, last: 1'b1};
                    else
                        push_word = '{left_out: '0, right_out: '0,
                                      sample_valid: 1'b0, last: 1'b1};
                    hold_valid_next = 1'b0;
                end
            endcase
        end
        out_valid_next = adv ? push : out_valid_reg;
        out_word_next  = push ? push_word : out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LATENCY; i++)
                tag_pipe_reg[i] <= '0;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
            hold_valid_reg <= 1'b0;
            hold_l_reg     <= '0;
            hold_r_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                tag_pipe_reg[0] <= tag_in;
                for (int i = 1; i < LANE_LATENCY; i++)
                    tag_pipe_reg[i] <= tag_pipe_reg[i-1];
            end
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
            hold_valid_reg <= hold_valid_next;
            hold_l_reg     <= hold_l_next;
            hold_r_reg     <= hold_r_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_word_reg;
endmodule
